@@ design/alive_supervision_monitor_assert.svh @@
// Assertion macros shared by the alive supervision monitor.
`ifndef ALIVE_SUPERVISION_MONITOR_ASSERT_SVH
`define ALIVE_SUPERVISION_MONITOR_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define ASM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alive supervision monitor: implication check failed");

// Next-cycle implication, checked out of reset only.
`define ASM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alive supervision monitor: next-cycle check failed");

`endif

@@ design/asm_pkg.sv @@
// Types and constants shared by the alive supervision monitor modules.
package asm_pkg;

  // Field widths.
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned OP_W      = 4;

  // Supervision status codes.
  localparam logic [1:0] ST_DEACT   = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;
  localparam logic [1:0] ST_EXPIRED = 2'd3;

  // Expiry causes.
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_LOSS = 2'd1;
  localparam logic [1:0] CAUSE_TOL  = 2'd2;
  localparam logic [1:0] CAUSE_OVF  = 2'd3;

  // Event kinds.
  localparam logic [2:0] REQ_CHECKPOINT = 3'd0;
  localparam logic [2:0] REQ_RUNNING    = 3'd1;
  localparam logic [2:0] REQ_STOPPED    = 3'd2;
  localparam logic [2:0] REQ_SYNC       = 3'd3;
  localparam logic [2:0] REQ_LOSS       = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_IND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAILED_TOL = 3'd5;

  // Datapath operations issued by the controller.
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_LOSS      = 4'd2;
  localparam logic [OP_W-1:0] OP_SYNC_LOSS = 4'd3;
  localparam logic [OP_W-1:0] OP_SYNC_END  = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV_INIT  = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd6;
  localparam logic [OP_W-1:0] OP_APPLY     = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL_STEP  = 4'd8;
  localparam logic [OP_W-1:0] OP_EVAL      = 4'd9;
  localparam logic [OP_W-1:0] OP_ADV       = 4'd10;
  localparam logic [OP_W-1:0] OP_ACT       = 4'd11;

  // Kinds of quiet-cycle skip.
  localparam logic [1:0] SKIP_NONE = 2'd0;
  localparam logic [1:0] SKIP_OK   = 2'd1;
  localparam logic [1:0] SKIP_UP   = 2'd2;
  localparam logic [1:0] SKIP_DOWN = 2'd3;

  // Sequencing limits.
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned MUL_STEPS   = 32;
  localparam int unsigned ITER_W      = 6;
  localparam int unsigned ECNT_W      = 3;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [TIME_W-1:0] event_time;
    logic              loss_cause;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] status_time;
    logic [1:0]        expire_cause;
    logic              recovery_request;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       lpend;
    logic       due;
    logic       cnt_zero;
    logic       skip_on;
    logic       fit;
    logic       adv;
    logic       emit;
  } dp_sts_t;

  typedef struct packed {
    logic push;
    logic flush;
  } oq_cmd_t;

  typedef struct packed {
    logic ready;
    logic pend_valid;
    logic out_free;
  } oq_sts_t;

endpackage

@@ design/asm_outq.sv @@
// Result stage: holds the newest status change until it is known whether it is the last one.
module asm_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  asm_pkg::oq_cmd_t    cmd,
  input  asm_pkg::out_item_t  rec,
  output asm_pkg::oq_sts_t    sts,
  output logic                out_valid,
  input  logic                out_stall,
  output asm_pkg::out_item_t  out_data
);

  logic               pend_valid_r, pend_valid_nxt;
  asm_pkg::out_item_t pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  asm_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;

  // A new change pushes the held one out; the end of an event releases it as last.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.push) begin
      if (pend_valid_r) begin
        out_data_nxt             = pend_r;
        out_data_nxt.last_result = 1'b0;
        out_valid_nxt            = 1'b1;
      end
      pend_nxt       = rec;
      pend_valid_nxt = 1'b1;
    end else if (cmd.flush) begin
      out_data_nxt             = pend_r;
      out_data_nxt.last_result = 1'b1;
      out_valid_nxt            = 1'b1;
      pend_valid_nxt           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.ready      = !pend_valid_r || out_free;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

@@ design/asm_dpath.sv @@
// Datapath: supervision state, configuration, shared divider and shift-add multiplier.
module asm_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [asm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [asm_pkg::CFG_DW-1:0]          cfg_wdata,
  input  asm_pkg::in_item_t                   in_data,
  input  asm_pkg::dp_cmd_t                    cmd,
  output asm_pkg::dp_sts_t                    sts,
  output asm_pkg::out_item_t                  rec
);

  localparam logic [asm_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam logic [asm_pkg::CNT_W-1:0]  CNT_MAX  = '1;

  // Configuration registers.
  logic [asm_pkg::TIME_W-1:0] len_r;
  logic [asm_pkg::CNT_W-1:0]  min_r, max_r, tol_r;
  logic                       minen_r, maxen_r;

  // Supervision state.
  logic [1:0]                 stat_r, stat_nxt;
  logic                       act_r, act_nxt;
  logic [asm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [asm_pkg::CNT_W-1:0]  fail_r, fail_nxt;
  logic [asm_pkg::TIME_W-1:0] ce_r, ce_nxt;
  logic [asm_pkg::TIME_W-1:0] lsync_r, lsync_nxt;
  logic [asm_pkg::TIME_W-1:0] attr_r, attr_nxt;
  logic                       lp_r, lp_nxt;

  // Current event.
  logic [2:0]                 req_r, req_nxt;
  logic [asm_pkg::TIME_W-1:0] t_r, t_nxt;
  logic                       cause_r, cause_nxt;

  // Skip arithmetic.
  logic [asm_pkg::TIME_W-1:0] q_r, q_nxt;
  logic [asm_pkg::TIME_W-1:0] rem_r, rem_nxt;
  logic [asm_pkg::CNT_W-1:0]  limit_r, limit_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [asm_pkg::TIME_W-1:0] mcand_r, mcand_nxt;

  logic                       is_sync, active, err, e0, fit, eval_adv;
  logic [asm_pkg::TIME_W-1:0] t_bound;
  logic [1:0]                 skip_kind;
  logic [asm_pkg::TIME_W:0]   adv_sum, start_sum, div_part;
  logic [asm_pkg::CNT_W-1:0]  s32;
  logic                       emit;
  logic [1:0]                 ecause;

  // Conditions derived from the present state.
  assign is_sync  = (req_r == asm_pkg::REQ_SYNC);
  assign active   = (stat_r == asm_pkg::ST_OK) || (stat_r == asm_pkg::ST_FAILED);
  assign t_bound  = is_sync ? t_r : t_r - 64'd1;
  assign err      = (minen_r && (cnt_r < min_r)) || (maxen_r && (cnt_r > max_r));
  assign e0       = minen_r && (min_r != '0);
  assign eval_adv = !err || (fail_r < tol_r);
  assign adv_sum  = {1'b0, ce_r} + {1'b0, len_r};
  assign start_sum = {1'b0, t_r} + {1'b0, len_r};
  assign div_part = {rem_r, q_r[asm_pkg::TIME_W-1]};
  assign fit      = (kind_r == asm_pkg::SKIP_OK) || (q_r <= {32'd0, limit_r});
  assign s32      = fit ? q_r[asm_pkg::CNT_W-1:0] : limit_r;

  // Which run of quiet cycles can be jumped over without visible change.
  always_comb begin
    priority if (stat_r == asm_pkg::ST_OK && !e0) begin
      skip_kind = asm_pkg::SKIP_OK;
    end else if (stat_r == asm_pkg::ST_FAILED && e0) begin
      skip_kind = asm_pkg::SKIP_UP;
    end else if (stat_r == asm_pkg::ST_FAILED) begin
      skip_kind = asm_pkg::SKIP_DOWN;
    end else begin
      skip_kind = asm_pkg::SKIP_NONE;
    end
  end

  // Next-state logic for each operation.
  always_comb begin
    stat_nxt  = stat_r;
    act_nxt   = act_r;
    cnt_nxt   = cnt_r;
    fail_nxt  = fail_r;
    ce_nxt    = ce_r;
    lsync_nxt = lsync_r;
    attr_nxt  = attr_r;
    lp_nxt    = lp_r;
    req_nxt   = req_r;
    t_nxt     = t_r;
    cause_nxt = cause_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    limit_nxt = limit_r;
    kind_nxt  = kind_r;
    mcand_nxt = mcand_r;
    emit      = 1'b0;
    ecause    = asm_pkg::CAUSE_NONE;
    unique case (cmd.op)
      asm_pkg::OP_LOAD: begin
        req_nxt   = in_data.req_type;
        t_nxt     = in_data.event_time;
        cause_nxt = in_data.loss_cause;
      end
      asm_pkg::OP_LOSS: begin
        lp_nxt   = 1'b1;
        attr_nxt = (cause_r || t_r == '0) ? lsync_r : t_r;
      end
      asm_pkg::OP_SYNC_LOSS: begin
        if (stat_r != asm_pkg::ST_EXPIRED) begin
          stat_nxt = asm_pkg::ST_EXPIRED;
          fail_nxt = tol_r;
          cnt_nxt  = '0;
          ce_nxt   = TIME_MAX;
          emit     = 1'b1;
          ecause   = asm_pkg::CAUSE_LOSS;
        end
        act_nxt   = 1'b1;
        lp_nxt    = 1'b0;
        lsync_nxt = t_r;
      end
      asm_pkg::OP_SYNC_END: begin
        lsync_nxt = t_r;
      end
      asm_pkg::OP_DIV_INIT: begin
        q_nxt    = t_bound - ce_r;
        rem_nxt  = '0;
        kind_nxt = skip_kind;
        if (skip_kind == asm_pkg::SKIP_UP && fail_r < tol_r) begin
          limit_nxt = tol_r - fail_r;
        end else if (skip_kind == asm_pkg::SKIP_DOWN && fail_r > 32'd1) begin
          limit_nxt = fail_r - 32'd1;
        end else begin
          limit_nxt = '0;
        end
      end
      asm_pkg::OP_DIV_STEP: begin
        // One restoring division step: quotient bits shift in at the bottom.
        if (div_part >= {1'b0, len_r}) begin
          rem_nxt = 64'(div_part - {1'b0, len_r});
          q_nxt   = {q_r[asm_pkg::TIME_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_part[asm_pkg::TIME_W-1:0];
          q_nxt   = {q_r[asm_pkg::TIME_W-2:0], 1'b0};
        end
      end
      asm_pkg::OP_APPLY: begin
        if (kind_r == asm_pkg::SKIP_UP) begin
          fail_nxt = fail_r + s32;
        end else if (kind_r == asm_pkg::SKIP_DOWN) begin
          fail_nxt = fail_r - s32;
        end
        if (fit) begin
          ce_nxt = t_bound - rem_r;
        end
        mcand_nxt = len_r;
      end
      asm_pkg::OP_MUL_STEP: begin
        // Shift-add: the cycle end accumulates the length times the step limit.
        if (limit_r[0]) begin
          ce_nxt = ce_r + mcand_r;
        end
        mcand_nxt = {mcand_r[asm_pkg::TIME_W-2:0], 1'b0};
        limit_nxt = {1'b0, limit_r[asm_pkg::CNT_W-1:1]};
      end
      asm_pkg::OP_EVAL: begin
        attr_nxt = ce_r;
        if (stat_r == asm_pkg::ST_OK) begin
          if (err) begin
            if (fail_r < tol_r) begin
              stat_nxt = asm_pkg::ST_FAILED;
              fail_nxt = fail_r + 32'd1;
              emit     = 1'b1;
            end else begin
              stat_nxt = asm_pkg::ST_EXPIRED;
              fail_nxt = tol_r;
              cnt_nxt  = '0;
              ce_nxt   = TIME_MAX;
              emit     = 1'b1;
              ecause   = asm_pkg::CAUSE_TOL;
            end
          end
        end else if (err) begin
          if (fail_r == CNT_MAX || fail_r >= tol_r) begin
            stat_nxt = asm_pkg::ST_EXPIRED;
            fail_nxt = tol_r;
            cnt_nxt  = '0;
            ce_nxt   = TIME_MAX;
            emit     = 1'b1;
            ecause   = (fail_r == CNT_MAX) ? asm_pkg::CAUSE_OVF : asm_pkg::CAUSE_TOL;
          end else begin
            fail_nxt = fail_r + 32'd1;
          end
        end else if (fail_r <= 32'd1) begin
          stat_nxt = asm_pkg::ST_OK;
          fail_nxt = '0;
          emit     = 1'b1;
        end else begin
          fail_nxt = fail_r - 32'd1;
        end
      end
      asm_pkg::OP_ADV: begin
        if (adv_sum[asm_pkg::TIME_W]) begin
          attr_nxt = TIME_MAX;
          stat_nxt = asm_pkg::ST_EXPIRED;
          fail_nxt = tol_r;
          cnt_nxt  = '0;
          ce_nxt   = TIME_MAX;
          emit     = 1'b1;
          ecause   = asm_pkg::CAUSE_OVF;
        end else begin
          ce_nxt  = adv_sum[asm_pkg::TIME_W-1:0];
          cnt_nxt = '0;
        end
      end
      asm_pkg::OP_ACT: begin
        if (req_r == asm_pkg::REQ_CHECKPOINT) begin
          if (active) begin
            if (cnt_r == CNT_MAX) begin
              attr_nxt = t_r;
              stat_nxt = asm_pkg::ST_EXPIRED;
              fail_nxt = tol_r;
              cnt_nxt  = '0;
              ce_nxt   = TIME_MAX;
              emit     = 1'b1;
              ecause   = asm_pkg::CAUSE_OVF;
            end else begin
              cnt_nxt = cnt_r + 32'd1;
            end
          end
        end else if (req_r == asm_pkg::REQ_RUNNING) begin
          if (!act_r) begin
            act_nxt = 1'b1;
            if (stat_r == asm_pkg::ST_DEACT) begin
              if (start_sum[asm_pkg::TIME_W]) begin
                attr_nxt = TIME_MAX;
                stat_nxt = asm_pkg::ST_EXPIRED;
                fail_nxt = tol_r;
                cnt_nxt  = '0;
                ce_nxt   = TIME_MAX;
                emit     = 1'b1;
                ecause   = asm_pkg::CAUSE_OVF;
              end else begin
                ce_nxt   = start_sum[asm_pkg::TIME_W-1:0];
                attr_nxt = t_r;
                stat_nxt = asm_pkg::ST_OK;
                fail_nxt = '0;
                emit     = 1'b1;
              end
            end
          end
        end else if (req_r == asm_pkg::REQ_STOPPED) begin
          if (act_r) begin
            act_nxt = 1'b0;
            if (stat_r != asm_pkg::ST_DEACT) begin
              attr_nxt = t_r;
              stat_nxt = asm_pkg::ST_DEACT;
              fail_nxt = '0;
              cnt_nxt  = '0;
              ce_nxt   = TIME_MAX;
              emit     = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 64'd1;
      min_r   <= '0;
      max_r   <= CNT_MAX;
      minen_r <= 1'b1;
      maxen_r <= 1'b1;
      tol_r   <= '0;
      stat_r  <= asm_pkg::ST_DEACT;
      act_r   <= 1'b0;
      cnt_r   <= '0;
      fail_r  <= '0;
      ce_r    <= TIME_MAX;
      lsync_r <= '0;
      attr_r  <= '0;
      lp_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          asm_pkg::REG_CYCLE_LEN:  len_r   <= (cfg_wdata == '0) ? 64'd1 : cfg_wdata;
          asm_pkg::REG_MIN_IND:    min_r   <= cfg_wdata[asm_pkg::CNT_W-1:0];
          asm_pkg::REG_MAX_IND:    max_r   <= cfg_wdata[asm_pkg::CNT_W-1:0];
          asm_pkg::REG_MIN_EN:     minen_r <= cfg_wdata[0];
          asm_pkg::REG_MAX_EN:     maxen_r <= cfg_wdata[0];
          asm_pkg::REG_FAILED_TOL: tol_r   <= cfg_wdata[asm_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      stat_r  <= stat_nxt;
      act_r   <= act_nxt;
      cnt_r   <= cnt_nxt;
      fail_r  <= fail_nxt;
      ce_r    <= ce_nxt;
      lsync_r <= lsync_nxt;
      attr_r  <= attr_nxt;
      lp_r    <= lp_nxt;
    end
    req_r   <= req_nxt;
    t_r     <= t_nxt;
    cause_r <= cause_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    limit_r <= limit_nxt;
    kind_r  <= kind_nxt;
    mcand_r <= mcand_nxt;
  end

  // Status towards the controller.
  assign sts.req      = req_r;
  assign sts.lpend    = lp_r;
  assign sts.due      = active && ((ce_r < t_r) || (ce_r == t_r && is_sync));
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.skip_on  = (skip_kind != asm_pkg::SKIP_NONE);
  assign sts.fit      = fit;
  assign sts.adv      = eval_adv;
  assign sts.emit     = emit;

  // Status change record built from the post-operation state.
  assign rec.status           = stat_nxt;
  assign rec.status_time      = attr_nxt;
  assign rec.expire_cause     = (stat_nxt == asm_pkg::ST_EXPIRED) ? ecause
                                                                  : asm_pkg::CAUSE_NONE;
  assign rec.recovery_request = (stat_nxt == asm_pkg::ST_EXPIRED);
  assign rec.last_result      = 1'b0;

endmodule

@@ design/asm_ctrl.sv @@
// Controller: sequences one event through dispatch, cycle evaluation and the final action.
module asm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  asm_pkg::dp_sts_t  dp_sts,
  output asm_pkg::dp_cmd_t  dp_cmd,
  input  asm_pkg::oq_sts_t  oq_sts,
  output asm_pkg::oq_cmd_t  oq_cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_LOOP  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_APPLY = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_ADV   = 4'd7;
  localparam logic [3:0] S_POST  = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;

  logic [3:0]                   state_r, state_nxt;
  logic [asm_pkg::ITER_W-1:0]   iter_r, iter_nxt;
  logic [asm_pkg::ECNT_W-1:0]   ecnt_r, ecnt_nxt;
  logic                         stepped;
  logic                         flush;
  logic [asm_pkg::OP_W-1:0]     op;

  // State sequencing and operation selection.
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    op        = asm_pkg::OP_NONE;
    stepped   = 1'b0;
    flush     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = asm_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (dp_sts.req == asm_pkg::REQ_LOSS) begin
          op        = asm_pkg::OP_LOSS;
          state_nxt = S_FLUSH;
        end else if (dp_sts.req == asm_pkg::REQ_SYNC && dp_sts.lpend) begin
          if (oq_sts.ready) begin
            op        = asm_pkg::OP_SYNC_LOSS;
            stepped   = 1'b1;
            state_nxt = S_FLUSH;
          end
        end else if (dp_sts.req == asm_pkg::REQ_SYNC) begin
          state_nxt = S_LOOP;
        end else if ((dp_sts.req == asm_pkg::REQ_CHECKPOINT ||
                      dp_sts.req == asm_pkg::REQ_RUNNING ||
                      dp_sts.req == asm_pkg::REQ_STOPPED) && !dp_sts.lpend) begin
          state_nxt = S_LOOP;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_LOOP: begin
        priority if (!dp_sts.due) begin
          state_nxt = S_POST;
        end else if (dp_sts.cnt_zero && dp_sts.skip_on) begin
          op        = asm_pkg::OP_DIV_INIT;
          iter_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_DIV: begin
        op       = asm_pkg::OP_DIV_STEP;
        iter_nxt = iter_r + 6'd1;
        if (iter_r == asm_pkg::ITER_W'(asm_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        op        = asm_pkg::OP_APPLY;
        iter_nxt  = '0;
        state_nxt = dp_sts.fit ? S_EVAL : S_MUL;
      end
      S_MUL: begin
        op       = asm_pkg::OP_MUL_STEP;
        iter_nxt = iter_r + 6'd1;
        if (iter_r == asm_pkg::ITER_W'(asm_pkg::MUL_STEPS - 1)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (oq_sts.ready) begin
          op        = asm_pkg::OP_EVAL;
          stepped   = 1'b1;
          state_nxt = dp_sts.adv ? S_ADV : S_LOOP;
        end
      end
      S_ADV: begin
        if (oq_sts.ready) begin
          op        = asm_pkg::OP_ADV;
          stepped   = 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_POST: begin
        if (dp_sts.req == asm_pkg::REQ_SYNC) begin
          op        = asm_pkg::OP_SYNC_END;
          state_nxt = S_FLUSH;
        end else if (oq_sts.ready) begin
          op        = asm_pkg::OP_ACT;
          stepped   = 1'b1;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!oq_sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (oq_sts.out_free) begin
          flush     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Status changes beyond the per-event limit are dropped.
  assign oq_cmd.push  = stepped && dp_sts.emit &&
                        (ecnt_r < asm_pkg::ECNT_W'(asm_pkg::MAX_RESULTS));
  assign oq_cmd.flush = flush;

  always_comb begin
    if (state_r == S_IDLE) begin
      ecnt_nxt = '0;
    end else if (oq_cmd.push) begin
      ecnt_nxt = ecnt_r + 3'd1;
    end else begin
      ecnt_nxt = ecnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ecnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ecnt_r  <= ecnt_nxt;
    end
    iter_r <= iter_nxt;
  end

  assign dp_cmd.op = op;
  assign in_stall  = (state_r != S_IDLE);

endmodule

@@ design/alive_supervision_monitor.sv @@
// Alive supervision monitor: one event at a time. An ordinary event goes through load, dispatch,
// the due-cycle check and the final action before the next beat is accepted; each due reference
// cycle adds an evaluation, and an advance when the cycle moves on. A data loss, a sync after a
// loss or an unused code goes from dispatch to the release. Jumping quiet cycles adds the 64-step
// divider, and the 32-step shift-add multiplier when its result does not fit; output stalls can
// hold it further. Synchronous active-low reset sets deactivated status and register defaults.
module alive_supervision_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  asm_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output asm_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [asm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [asm_pkg::CFG_DW-1:0]       cfg_wdata
);

`include "alive_supervision_monitor_assert.svh"

  asm_pkg::dp_cmd_t   dp_cmd;
  asm_pkg::dp_sts_t   dp_sts;
  asm_pkg::oq_cmd_t   oq_cmd;
  asm_pkg::oq_sts_t   oq_sts;
  asm_pkg::out_item_t rec;

  // Sequencer for each event.
  asm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_sts   (dp_sts),
    .dp_cmd   (dp_cmd),
    .oq_sts   (oq_sts),
    .oq_cmd   (oq_cmd)
  );

  // Supervision state and arithmetic.
  asm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .rec       (rec)
  );

  // Result beats towards the consumer.
  asm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (oq_cmd),
    .rec       (rec),
    .sts       (oq_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A new event is taken only after the previous one has released its last change.
  `ASM_ASSERT_IMP(a_idle_empty, in_valid && !in_stall, !oq_sts.pend_valid)
  // The controller is busy in the cycle after it takes an event.
  `ASM_ASSERT_NXT(a_busy_after, in_valid && !in_stall, in_stall)
  // A status change is only pushed when the result stage can make room for it.
  `ASM_ASSERT_IMP(a_push_room, oq_cmd.push, oq_sts.ready)
  // Release as last only happens with a held change and a free output register.
  `ASM_ASSERT_IMP(a_flush_ok, oq_cmd.flush, oq_sts.pend_valid && oq_sts.out_free)

endmodule

@@ sim/alive_supervision_monitor_tb.sv @@
// Self-checking testbench for the alive supervision monitor, with its own status tracker.
module alive_supervision_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TAIL_CYCLES = 1000;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned SHOW_LIMIT  = 10;
  localparam logic [63:0] ALL_ONES64  = '1;
  localparam logic [31:0] ALL_ONES32  = '1;
  // Request codes that the block must ignore.
  localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  asm_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  asm_pkg::out_item_t            out_data;
  logic                          cfg_we = 1'b0;
  logic [asm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [asm_pkg::CFG_DW-1:0]    cfg_wdata = '0;

  // Stimulus and checking bookkeeping.
  asm_pkg::in_item_t  pending[$];
  asm_pkg::out_item_t step_changes[$];
  asm_pkg::out_item_t status_due[$];
  logic        calm = 1'b0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned faults = 0;
  int unsigned results_seen = 0;
  int unsigned events_queued = 0;
  int unsigned events_taken = 0;
  int unsigned settings_used = 0;
  logic [63:0] t_now = '0;

  // Mirror of the configuration registers.
  logic [63:0] set_len = 64'd1;
  logic [31:0] set_min = '0;
  logic [31:0] set_max = ALL_ONES32;
  logic        set_min_on = 1'b1;
  logic        set_max_on = 1'b1;
  logic [31:0] set_tol = '0;

  // Tracked supervision state.
  logic [1:0]  sv_status = asm_pkg::ST_DEACT;
  logic        sv_active = 1'b0;
  logic        sv_loss = 1'b0;
  logic        sv_loss_kind = 1'b0;
  logic [31:0] sv_cp = '0;
  logic [31:0] sv_fails = '0;
  logic [63:0] sv_end = ALL_ONES64;
  logic [63:0] sv_sync = '0;
  logic [63:0] sv_stamp = '0;

  alive_supervision_monitor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Records one status change of the current event, capped at the block's limit.
  function automatic void note_change(input logic [1:0] cause);
    asm_pkg::out_item_t r;
    if (step_changes.size() >= asm_pkg::MAX_RESULTS) return;
    r.status           = sv_status;
    r.status_time      = sv_stamp;
    r.expire_cause     = (sv_status == asm_pkg::ST_EXPIRED) ? cause : asm_pkg::CAUSE_NONE;
    r.recovery_request = (sv_status == asm_pkg::ST_EXPIRED);
    r.last_result      = 1'b0;
    step_changes.push_back(r);
  endfunction

  function automatic void enter_expired(input logic [1:0] cause);
    sv_status = asm_pkg::ST_EXPIRED;
    sv_fails  = set_tol;
    sv_cp     = '0;
    sv_end    = ALL_ONES64;
    note_change(cause);
  endfunction

  function automatic void enter_ok();
    sv_status = asm_pkg::ST_OK;
    sv_fails  = '0;
    note_change(asm_pkg::CAUSE_NONE);
  endfunction

  // Opens a reference cycle at base; an end past all ones expires the process.
  function automatic bit open_cycle(input logic [63:0] base);
    if (base > ALL_ONES64 - set_len) begin
      sv_stamp = ALL_ONES64;
      enter_expired(asm_pkg::CAUSE_OVF);
      return 1'b0;
    end
    sv_end = base + set_len;
    return 1'b1;
  endfunction

  function automatic void next_cycle();
    if (open_cycle(sv_end)) sv_cp = '0;
  endfunction

  function automatic bit count_bad(input logic [31:0] c);
    return (set_min_on && c < set_min) || (set_max_on && c > set_max);
  endfunction

  // Judges the reference cycle that ends at sv_end.
  function automatic void close_cycle();
    bit bad;
    bad = count_bad(sv_cp);
    sv_stamp = sv_end;
    if (sv_status == asm_pkg::ST_OK) begin
      if (!bad) begin
        next_cycle();
      end else if (sv_fails < set_tol) begin
        sv_status = asm_pkg::ST_FAILED;
        sv_fails++;
        note_change(asm_pkg::CAUSE_NONE);
        next_cycle();
      end else begin
        enter_expired(asm_pkg::CAUSE_TOL);
      end
    end else if (bad) begin
      if (sv_fails == ALL_ONES32) begin
        enter_expired(asm_pkg::CAUSE_OVF);
      end else begin
        sv_fails++;
        if (sv_fails <= set_tol) next_cycle();
        else enter_expired(asm_pkg::CAUSE_TOL);
      end
    end else begin
      if (sv_fails <= 1) enter_ok();
      else sv_fails--;
      next_cycle();
    end
  endfunction

  // Judges every cycle that ends before t (or at t for a sync), jumping quiet runs.
  function automatic void catch_up(input logic [63:0] t, input bit at_sync);
    logic [63:0] bound;
    logic [63:0] span;
    logic [63:0] s;
    logic [63:0] f;
    bit          e0;
    while ((sv_status == asm_pkg::ST_OK || sv_status == asm_pkg::ST_FAILED) &&
           (sv_end < t || (sv_end == t && at_sync))) begin
      if (sv_cp == 0) begin
        bound = at_sync ? t : t - 1;
        span  = (bound - sv_end) / set_len;
        e0    = count_bad('0);
        s     = '0;
        f     = {32'd0, sv_fails};
        if (sv_status == asm_pkg::ST_OK && !e0) begin
          s = span;
        end else if (sv_status == asm_pkg::ST_FAILED && e0) begin
          if (f < set_tol) s = set_tol - f;
          if (s > span) s = span;
          f = f + s;
        end else if (sv_status == asm_pkg::ST_FAILED && !e0) begin
          if (f > 1) s = f - 1;
          if (s > span) s = span;
          f = f - s;
        end
        sv_fails = f[31:0];
        sv_end   = sv_end + s * set_len;
      end
      close_cycle();
    end
  endfunction

  // Works out the status changes that one accepted beat causes.
  function automatic void track_event(input asm_pkg::in_item_t it);
    asm_pkg::out_item_t r;
    logic [63:0]        t;
    t = it.event_time;
    step_changes.delete();
    case (it.req_type)
      asm_pkg::REQ_LOSS: begin
        sv_loss      = 1'b1;
        sv_loss_kind = it.loss_cause;
        sv_stamp     = (it.loss_cause || t == 0) ? sv_sync : t;
      end
      asm_pkg::REQ_SYNC: begin
        if (sv_loss) begin
          if (sv_status != asm_pkg::ST_EXPIRED) enter_expired(asm_pkg::CAUSE_LOSS);
          sv_active = 1'b1;
          sv_loss   = 1'b0;
        end else begin
          catch_up(t, 1'b1);
        end
        sv_sync = t;
      end
      asm_pkg::REQ_CHECKPOINT, asm_pkg::REQ_RUNNING, asm_pkg::REQ_STOPPED: begin
        if (!sv_loss) begin
          catch_up(t, 1'b0);
          if (it.req_type == asm_pkg::REQ_CHECKPOINT) begin
            if (sv_status == asm_pkg::ST_OK || sv_status == asm_pkg::ST_FAILED) begin
              if (sv_cp == ALL_ONES32) begin
                sv_stamp = t;
                enter_expired(asm_pkg::CAUSE_OVF);
              end else begin
                sv_cp++;
              end
            end
          end else if (it.req_type == asm_pkg::REQ_RUNNING) begin
            if (!sv_active) begin
              sv_active = 1'b1;
              if (sv_status == asm_pkg::ST_DEACT) begin
                if (open_cycle(t)) begin
                  sv_stamp = t;
                  enter_ok();
                end
              end
            end
          end else if (sv_active) begin
            sv_active = 1'b0;
            if (sv_status != asm_pkg::ST_DEACT) begin
              sv_stamp  = t;
              sv_status = asm_pkg::ST_DEACT;
              sv_fails  = '0;
              sv_cp     = '0;
              sv_end    = ALL_ONES64;
              note_change(asm_pkg::CAUSE_NONE);
            end
          end
        end
      end
      default: ;
    endcase
    foreach (step_changes[i]) begin
      r = step_changes[i];
      r.last_result = (i == step_changes.size() - 1);
      status_due.push_back(r);
    end
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= SHOW_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // Compares one status change from the block with the oldest one due.
  function automatic void check_change(input asm_pkg::out_item_t got);
    asm_pkg::out_item_t want;
    results_seen++;
    if (status_due.size() == 0) begin
      note_fault($sformatf("unexpected status change st=%0d t=%0h cause=%0d rec=%0d last=%0d",
                           got.status, got.status_time, got.expire_cause,
                           got.recovery_request, got.last_result));
      return;
    end
    want = status_due.pop_front();
    if (got.status !== want.status || got.status_time !== want.status_time ||
        got.expire_cause !== want.expire_cause ||
        got.recovery_request !== want.recovery_request ||
        got.last_result !== want.last_result)
      note_fault($sformatf({"want st=%0d t=%0h cause=%0d rec=%0d last=%0d, ",
                            "got st=%0d t=%0h cause=%0d rec=%0d last=%0d"},
                           want.status, want.status_time, want.expire_cause,
                           want.recovery_request, want.last_result,
                           got.status, got.status_time, got.expire_cause,
                           got.recovery_request, got.last_result));
  endfunction

  function automatic void offer(input logic [2:0] req, input logic [63:0] t, input logic cause);
    asm_pkg::in_item_t it;
    it.req_type   = req;
    it.event_time = t;
    it.loss_cause = cause;
    pending.push_back(it);
    if (req <= asm_pkg::REQ_LOSS) events_queued++;
  endfunction

  function automatic logic [63:0] step_gap();
    return (set_len * $urandom_range(7)) / 4;
  endfunction

  // Queues a supervised session: activation, then mostly checkpoints and syncs with noise.
  function automatic void queue_traffic(input int unsigned n);
    int unsigned pick;
    int unsigned made;
    logic [63:0] back;
    made  = 2;
    t_now = t_now + set_len * 2;
    offer(asm_pkg::REQ_STOPPED, t_now, 1'($urandom));
    offer(asm_pkg::REQ_RUNNING, t_now, 1'($urandom));
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 52) begin
        t_now = t_now + step_gap();
        offer(asm_pkg::REQ_CHECKPOINT, t_now, 1'($urandom));
      end else if (pick < 62) begin
        t_now = t_now + step_gap();
        offer(asm_pkg::REQ_SYNC, t_now, 1'($urandom));
      end else if (pick < 67) begin
        offer(asm_pkg::REQ_LOSS, ($urandom_range(3) == 0) ? 64'd0 : t_now, 1'($urandom));
      end else if (pick < 73) begin
        t_now = t_now + step_gap();
        offer(asm_pkg::REQ_STOPPED, t_now, 1'($urandom));
        t_now = t_now + step_gap();
        offer(asm_pkg::REQ_RUNNING, t_now, 1'($urandom));
        made++;
      end else if (pick < 80) begin
        // A long silence that spans many reference cycles.
        t_now = t_now + set_len * $urandom_range(600, 2);
        offer(pick[0] ? asm_pkg::REQ_CHECKPOINT : asm_pkg::REQ_SYNC, t_now, 1'($urandom));
      end else if (pick < 86) begin
        // A checkpoint stamped no later than the ones already sent.
        back = set_len * $urandom_range(3) + $urandom_range(3);
        offer(asm_pkg::REQ_CHECKPOINT, (back < t_now) ? t_now - back : 64'd0, 1'($urandom));
      end else if (pick < 90) begin
        offer(asm_pkg::REQ_LOSS + 3'($urandom_range(3, 1)), {$urandom, $urandom},
              1'($urandom));
        made--;
      end else begin
        offer(pick[0] ? asm_pkg::REQ_RUNNING : asm_pkg::REQ_STOPPED, t_now, 1'($urandom));
      end
      made++;
    end
  endfunction

  // Writes one register and keeps the mirror in step.
  task automatic write_reg(input logic [asm_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      asm_pkg::REG_CYCLE_LEN:  set_len = (val == 0) ? 64'd1 : val;
      asm_pkg::REG_MIN_IND:    set_min = val[31:0];
      asm_pkg::REG_MAX_IND:    set_max = val[31:0];
      asm_pkg::REG_MIN_EN:     set_min_on = val[0];
      asm_pkg::REG_MAX_EN:     set_max_on = val[0];
      asm_pkg::REG_FAILED_TOL: set_tol = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [63:0] len, input logic [31:0] lo,
                               input logic [31:0] hi, input logic lo_on,
                               input logic hi_on, input logic [31:0] tol);
    write_reg(asm_pkg::REG_CYCLE_LEN, len);
    write_reg(asm_pkg::REG_MIN_IND, {32'd0, lo});
    write_reg(asm_pkg::REG_MAX_IND, {32'd0, hi});
    write_reg(asm_pkg::REG_MIN_EN, {63'd0, lo_on});
    write_reg(asm_pkg::REG_MAX_EN, {63'd0, hi_on});
    write_reg(asm_pkg::REG_FAILED_TOL, {32'd0, tol});
    settings_used++;
  endtask

  // Waits until every queued beat is in and every due change is out, then lets the block finish.
  task automatic settle();
    while (pending.size() != 0 || in_valid || status_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Event driver: offers the next queued beat, idling at random unless calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        track_event(in_data);
        events_taken++;
      end
      if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so that the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Status monitor: checks each accepted beat and stalls at random or during a hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_change(out_data);
      out_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // Reset settings: ignored beats, activation, data loss of both causes and a clock error,
    // and a start so late that the first cycle cannot end.
    offer(asm_pkg::REQ_CHECKPOINT, 64'd5, 1'b0);
    offer(REQ_UNUSED_LO, 64'd7, 1'b1);
    offer(REQ_UNUSED_HI, ALL_ONES64, 1'b0);
    offer(asm_pkg::REQ_STOPPED, 64'd6, 1'b0);
    offer(asm_pkg::REQ_RUNNING, 64'd10, 1'b0);
    offer(asm_pkg::REQ_CHECKPOINT, 64'd11, 1'b0);
    offer(asm_pkg::REQ_CHECKPOINT, 64'd50, 1'b1);
    offer(asm_pkg::REQ_SYNC, 64'd60, 1'b0);
    offer(asm_pkg::REQ_LOSS, 64'd70, 1'b0);
    offer(asm_pkg::REQ_CHECKPOINT, 64'd80, 1'b0);
    offer(asm_pkg::REQ_SYNC, 64'd90, 1'b0);
    offer(asm_pkg::REQ_STOPPED, 64'd100, 1'b0);
    offer(asm_pkg::REQ_RUNNING, 64'd110, 1'b0);
    offer(asm_pkg::REQ_LOSS, 64'd120, 1'b1);
    offer(asm_pkg::REQ_LOSS, 64'd0, 1'b0);
    offer(asm_pkg::REQ_SYNC, 64'd130, 1'b0);
    offer(asm_pkg::REQ_STOPPED, 64'd140, 1'b0);
    offer(asm_pkg::REQ_RUNNING, ALL_ONES64, 1'b0);
    offer(asm_pkg::REQ_STOPPED, ALL_ONES64, 1'b1);
    settle();

    // Unbounded tolerance with an unmet minimum: the failed-cycle counter reaches its top value.
    write_reg(asm_pkg::REG_FAILED_TOL, {32'd0, ALL_ONES32});
    write_reg(asm_pkg::REG_MIN_IND, 64'd5);
    write_reg(asm_pkg::REG_MIN_EN, 64'd1);
    settings_used++;
    offer(asm_pkg::REQ_RUNNING, 64'd100, 1'b0);
    offer(asm_pkg::REQ_SYNC, 64'h0000_0100_0000_0000, 1'b0);
    offer(asm_pkg::REQ_STOPPED, 64'h0000_0100_0000_0001, 1'b0);
    settle();

    // Longest cycle with both checks off: the cycle end runs past all ones at a sync.
    write_reg(asm_pkg::REG_CYCLE_LEN, ALL_ONES64);
    write_reg(asm_pkg::REG_MIN_EN, 64'd0);
    write_reg(asm_pkg::REG_MAX_EN, 64'd0);
    settings_used++;
    offer(asm_pkg::REQ_RUNNING, 64'd0, 1'b0);
    offer(asm_pkg::REQ_CHECKPOINT, ALL_ONES64, 1'b0);
    offer(asm_pkg::REQ_SYNC, ALL_ONES64, 1'b0);
    offer(asm_pkg::REQ_STOPPED, ALL_ONES64, 1'b0);
    settle();

    // Random sessions under a range of settings.
    t_now = 64'd1000;
    phase = 0;
    while (events_queued < 110 && phase < 14) begin
      case (phase)
        0: load_settings(64'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0);
        1: load_settings(64'd12, 32'd1, 32'd3, 1'b1, 1'b1, 32'd2);
        3: load_settings({24'd0, 8'($urandom_range(255, 1)), 32'($urandom)},
                         32'($urandom_range(2)), 32'($urandom_range(4, 1)),
                         1'b1, 1'b1, 32'($urandom_range(3)));
        5: load_settings(64'd20, ALL_ONES32, ALL_ONES32, 1'b0, 1'b1, ALL_ONES32);
        default: load_settings(64'($urandom_range(120, 1)), 32'($urandom_range(3)),
                               32'($urandom_range(5)), 1'($urandom_range(3) != 0),
                               1'($urandom_range(3) != 0), 32'($urandom_range(4)));
      endcase
      calm = (phase == 2);
      queue_traffic(18);
      if (phase == 1) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      settle();
      calm = 1'b0;
      phase++;
    end

    if (status_due.size() != 0) begin
      faults += status_due.size();
      $display("%0d expected status changes never arrived", status_due.size());
    end
    $display("Covered %0d supervision events under %0d register settings,",
             events_taken, settings_used);
    $display("with %0d status changes compared and %0d mismatches.", results_seen, faults);
    if (faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
